>>> hdl/lsst_pkg.sv
// ----------------------------------------------------------------------------
// lsst_pkg
// Shared types, register indexes and helpers for lane segment selection
// ----------------------------------------------------------------------------
`default_nettype none

package lsst_pkg;

    localparam int FIELD_BITS = 12;
    localparam int OUT_BITS   = 16;
    localparam int NUM_BITS   = 36;
    localparam int DEN_BITS   = 18;
    localparam int SUM_BITS   = 37;

    localparam logic [1:0] REG_SLOPE_LIMIT    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_AVERAGE_LENGTH = 2'd2;

    localparam logic [9:0]  SLOPE_LIMIT_RESET    = 10'd77;
    localparam logic [11:0] FRAME_HEIGHT_RESET   = 12'd480;
    localparam logic [7:0]  AVERAGE_LENGTH_RESET = 8'd20;

    // one third as 2731 / 2^13, exact for 12-bit heights
    localparam logic [11:0] THIRD_MUL   = 12'd2731;
    localparam int          THIRD_SHIFT = 13;

    typedef struct packed {
        logic                        start;
        logic signed [NUM_BITS-1:0]  dividend;
        logic signed [DEN_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [NUM_BITS-1:0]  quotient;
    } div_rsp_t;

    function automatic logic signed [OUT_BITS-1:0] sat16(input logic signed [SUM_BITS-1:0] v);
        logic signed [OUT_BITS-1:0] r;
        if (v > 37'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -37'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[OUT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lane_segment_select_track.sv
// ----------------------------------------------------------------------------
// lane_segment_select_track
// Picks the longest left and right lane segment of each frame and tracks
// both lane lines with a moving average
//
//   channel   dir   payload (low bit up)
//   s_        in    tdata: start_x, start_y, end_x, end_y; tuser: has_segment;
//                   tlast: frame_last
//   m_        out   tdata: left top x/y, left bottom x/y, right top x/y,
//                   right bottom x/y; tuser: left_fallback, right_fallback
//   cfg_      in    index, data
//
// segments stream in at one per cycle through a two-stage front end, unless
// a frame end waits on a full queue; the back end runs each frame end on
// the shared divider, at most two divisions per row cut, at most one per average fold
// a two-entry queue lets the front end take the next frame meanwhile
// synchronous reset clears best candidates, averages and all handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module lane_segment_select_track #(
    parameter int COORD_BITS = 12
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // start_x, start_y, end_x, end_y
    input  wire logic         s_tuser,   // has_segment
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // l top x, l top y, l bot x, l bot y, r same
    output logic [1:0]        m_tuser,   // left_fallback, right_fallback
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [11:0]  cfg_data
);

    localparam int JOB_BITS = 8 * COORD_BITS + 2;

    logic [9:0]  slope_limit_reg;
    logic [11:0] frame_height_reg;
    logic [7:0]  average_length_reg;

    logic [3:0][lsst_pkg::FIELD_BITS-1:0] coords;
    logic                front_valid;
    logic                front_ready;
    logic [JOB_BITS-1:0] front_data;
    logic                job_valid;
    logic                job_ready;
    logic [JOB_BITS-1:0] job_data;
    lsst_pkg::div_req_t  div_req;
    lsst_pkg::div_rsp_t  div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_limit_reg    <= lsst_pkg::SLOPE_LIMIT_RESET;
            frame_height_reg   <= lsst_pkg::FRAME_HEIGHT_RESET;
            average_length_reg <= lsst_pkg::AVERAGE_LENGTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lsst_pkg::REG_SLOPE_LIMIT:    slope_limit_reg    <= cfg_data[9:0];
                lsst_pkg::REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                lsst_pkg::REG_AVERAGE_LENGTH: average_length_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            coords[i] = s_tdata[i*lsst_pkg::FIELD_BITS +: lsst_pkg::FIELD_BITS];
        end
    end

    lsst_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .has_segment (s_tuser),
        .coords      (coords),
        .frame_last  (s_tlast),
        .slope_limit (slope_limit_reg),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job_data    (front_data)
    );

    lsst_fifo #(.WIDTH(JOB_BITS)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (job_valid),
        .out_ready (job_ready),
        .out_data  (job_data)
    );

    lsst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lsst_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job_data       (job_data),
        .frame_height   (frame_height_reg),
        .average_length (average_length_reg),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_data         (m_tdata),
        .m_user         (m_tuser)
    );

endmodule

`default_nettype wire

>>> hdl/lsst_fifo.sv
// ----------------------------------------------------------------------------
// lsst_fifo
// Two-entry queue between the segment front end and the frame-end back end
// ----------------------------------------------------------------------------
`default_nettype none

module lsst_fifo #(
    parameter int WIDTH = 98
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/lsst_front.sv
// ----------------------------------------------------------------------------
// lsst_front
// Sorts segments by slope and keeps the longest candidate of each side
// ----------------------------------------------------------------------------
`default_nettype none

module lsst_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    has_segment,
    input  wire logic [3:0][lsst_pkg::FIELD_BITS-1:0]    coords,
    input  wire logic                                    frame_last,
    input  wire logic [9:0]                              slope_limit,
    output logic                                         job_valid,
    input  wire logic                                    job_ready,
    output logic [8*COORD_BITS+1:0]                      job_data
);

    localparam int C        = COORD_BITS;
    localparam int LEN_BITS = 2 * COORD_BITS + 1;
    localparam int CMP_BITS = COORD_BITS + 12;

    logic [3:0][C-1:0]       c_in;
    logic signed [C:0]       dx;
    logic signed [C:0]       dy;
    logic signed [C:0]       dx_abs;
    logic signed [C:0]       dy_norm;
    logic signed [LEN_BITS:0] sq_sum;

    logic                    p_valid_reg;
    logic                    p_has_reg;
    logic                    p_last_reg;
    logic [3:0][C-1:0]       p_c_reg;
    logic [C-1:0]            p_adx_reg;
    logic signed [C:0]       p_dy_reg;
    logic [LEN_BITS-1:0]     p_len_reg;

    logic [3:0][C-1:0]       lbest_reg;
    logic [3:0][C-1:0]       rbest_reg;
    logic [LEN_BITS-1:0]     llen_reg;
    logic [LEN_BITS-1:0]     rlen_reg;

    logic [C+9:0]            m_adx;
    logic signed [CMP_BITS-1:0] dy_s;
    logic signed [CMP_BITS-1:0] thr;
    logic                    is_left;
    logic                    is_right;
    logic                    l_upd;
    logic                    r_upd;
    logic [3:0][C-1:0]       lbest_next;
    logic [3:0][C-1:0]       rbest_next;
    logic [LEN_BITS-1:0]     llen_next;
    logic [LEN_BITS-1:0]     rlen_next;
    logic                    fire;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_in[i] = C'(coords[i]);
        end
    end

    assign dx      = $signed({1'b0, c_in[2]}) - $signed({1'b0, c_in[0]});
    assign dy      = $signed({1'b0, c_in[3]}) - $signed({1'b0, c_in[1]});
    assign sq_sum  = dx * dx + dy * dy;
    assign dx_abs  = dx[C] ? -dx : dx;
    assign dy_norm = dx[C] ? -dy : dy;

    // slope test against the threshold by cross-multiply
    assign m_adx = slope_limit * p_adx_reg;
    assign dy_s  = {{(CMP_BITS-C-9){p_dy_reg[C]}}, p_dy_reg, 8'b0};
    assign thr   = $signed({2'b0, m_adx});

    always_comb begin
        if (p_adx_reg == '0) begin
            is_left  = (p_dy_reg < 0);
            is_right = (p_dy_reg > 0);
        end else begin
            is_left  = (dy_s < -thr);
            is_right = (dy_s > thr);
        end
    end

    assign l_upd      = p_has_reg && is_left && (p_len_reg > llen_reg);
    assign r_upd      = p_has_reg && !is_left && is_right && (p_len_reg > rlen_reg);
    assign lbest_next = l_upd ? p_c_reg : lbest_reg;
    assign rbest_next = r_upd ? p_c_reg : rbest_reg;
    assign llen_next  = l_upd ? p_len_reg : llen_reg;
    assign rlen_next  = r_upd ? p_len_reg : rlen_reg;

    assign job_valid = p_valid_reg && p_last_reg;
    assign job_data  = {(rlen_next == '0), (llen_next == '0), rbest_next, lbest_next};
    assign fire      = p_valid_reg && (!p_last_reg || job_ready);
    assign s_ready   = !p_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            p_has_reg  <= has_segment;
            p_last_reg <= frame_last;
            p_c_reg    <= c_in;
            p_adx_reg  <= dx_abs[C-1:0];
            p_dy_reg   <= dy_norm;
            p_len_reg  <= sq_sum[LEN_BITS-1:0];
        end
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            lbest_reg   <= '0;
            rbest_reg   <= '0;
            llen_reg    <= '0;
            rlen_reg    <= '0;
        end else begin
            if (s_ready) begin
                p_valid_reg <= s_valid;
            end
            if (fire) begin
                if (p_last_reg) begin
                    lbest_reg <= '0;
                    rbest_reg <= '0;
                    llen_reg  <= '0;
                    rlen_reg  <= '0;
                end else begin
                    lbest_reg <= lbest_next;
                    rbest_reg <= rbest_next;
                    llen_reg  <= llen_next;
                    rlen_reg  <= rlen_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/lsst_div.sv
// ----------------------------------------------------------------------------
// lsst_div
// Signed truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lsst_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lsst_pkg::div_req_t req,
    output lsst_pkg::div_rsp_t      rsp
);

    localparam int NB = lsst_pkg::NUM_BITS;
    localparam int DB = lsst_pkg::DEN_BITS;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic [DB-1:0] rem_reg;
    logic [NB-1:0] q_reg;
    logic [DB-1:0] den_reg;
    logic          neg_reg;
    logic signed [NB-1:0] quo_reg;

    logic [DB:0]   trial;
    logic          ge;
    logic [DB:0]   rem_n;
    logic [NB-1:0] q_n;

    assign trial = {rem_reg, q_reg[NB-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign rem_n = ge ? (trial - {1'b0, den_reg}) : trial;
    assign q_n   = {q_reg[NB-2:0], ge};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            q_reg   <= req.dividend[NB-1] ? NB'(-req.dividend) : NB'(req.dividend);
            den_reg <= req.divisor[DB-1] ? DB'(-req.divisor) : DB'(req.divisor);
            neg_reg <= req.dividend[NB-1] ^ req.divisor[DB-1];
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_n[DB-1:0];
            q_reg   <= q_n;
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(NB-1)) begin
                quo_reg <= neg_reg ? -$signed(q_n) : $signed(q_n);
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'(NB-1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/lsst_back.sv
// ----------------------------------------------------------------------------
// lsst_back
// Frame-end sequencer: cuts each side's line at both rows and folds the
// cut points into the moving averages
// ----------------------------------------------------------------------------
`default_nettype none

module lsst_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      job_valid,
    output logic                           job_ready,
    input  wire logic [8*COORD_BITS+1:0]   job_data,
    input  wire logic [11:0]               frame_height,
    input  wire logic [7:0]                average_length,
    output lsst_pkg::div_req_t             div_req,
    input  wire lsst_pkg::div_rsp_t        div_rsp,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [127:0]                   m_data,
    output logic [1:0]                     m_user
);

    localparam int C  = COORD_BITS;
    localparam int NB = lsst_pkg::NUM_BITS;
    localparam int DB = lsst_pkg::DEN_BITS;
    localparam int SB = lsst_pkg::SUM_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_CUT, ST_MUL, ST_ISSUE, ST_WAIT, ST_FOLD, ST_DONE
    } state_t;

    typedef enum logic [1:0] {OP_X, OP_Y, OP_F} op_t;

    state_t             state_reg;
    op_t                op_reg;
    logic               side_reg;
    logic               phase_reg;
    logic [1:0]         k_reg;
    logic [7:0][C-1:0]  lines_reg;
    logic [1:0]         fb_reg;
    logic [11:0]        ytop_reg;
    logic signed [15:0] l_reg [4];
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic signed [15:0] smp_reg [4];
    logic signed [15:0] avg_reg [2][4];
    logic signed [NB-1:0] prod_reg;
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;
    logic [1:0]         m_user_reg;

    logic [23:0]        h_mul;
    logic [11:0]        ytop_n;
    logic [8:0]         neff;
    logic [11:0]        yref;
    logic signed [15:0] l_src [4];
    logic signed [16:0] dx_n;
    logic signed [16:0] dy_n;
    logic signed [15:0] avg_cur;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [15:0] mul_add;
    logic signed [NB-1:0] prod_n;
    logic signed [15:0] base;
    logic signed [SB-1:0] cut_sum;
    logic signed [15:0] cut_sat;

    assign h_mul  = frame_height * lsst_pkg::THIRD_MUL;
    assign ytop_n = frame_height - {1'b0, h_mul[23:lsst_pkg::THIRD_SHIFT]};
    assign neff   = (average_length == 8'd0) ? 9'd1 : {1'b0, average_length};
    assign yref   = phase_reg ? frame_height : ytop_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (fb_reg[side_reg]) begin
                l_src[i] = avg_reg[side_reg][i];
            end else begin
                l_src[i] = 16'(lines_reg[{side_reg, 2'(i)}]);
            end
        end
    end

    assign dx_n    = $signed({l_src[2][15], l_src[2]}) - $signed({l_src[0][15], l_src[0]});
    assign dy_n    = $signed({l_src[3][15], l_src[3]}) - $signed({l_src[1][15], l_src[1]});
    assign avg_cur = avg_reg[side_reg][k_reg];

    always_comb begin
        unique case (op_reg)
            OP_X: begin
                mul_a   = $signed({6'b0, yref}) - $signed({{2{l_reg[1][15]}}, l_reg[1]});
                mul_b   = $signed({dx_reg[16], dx_reg});
                mul_add = '0;
            end
            OP_Y: begin
                mul_a   = $signed({{2{smp_reg[{phase_reg, 1'b0}][15]}},
                                   smp_reg[{phase_reg, 1'b0}]})
                        - $signed({{2{l_reg[0][15]}}, l_reg[0]});
                mul_b   = $signed({dy_reg[16], dy_reg});
                mul_add = '0;
            end
            default: begin
                mul_a   = $signed({{2{avg_cur[15]}}, avg_cur});
                mul_b   = $signed({9'b0, neff - 9'd1});
                mul_add = smp_reg[k_reg];
            end
        endcase
    end

    assign prod_n = mul_a * mul_b + mul_add;

    always_comb begin
        div_req.start    = (state_reg == ST_ISSUE);
        div_req.dividend = prod_reg;
        unique case (op_reg)
            OP_X:    div_req.divisor = $signed({dy_reg[16], dy_reg});
            OP_Y:    div_req.divisor = $signed({dx_reg[16], dx_reg});
            default: div_req.divisor = $signed({9'b0, neff});
        endcase
    end

    assign base    = (op_reg == OP_X) ? l_reg[0] : l_reg[1];
    assign cut_sum = $signed({{(SB-16){base[15]}}, base})
                   + $signed({div_rsp.quotient[NB-1], div_rsp.quotient});
    assign cut_sat = lsst_pkg::sat16(cut_sum);

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign m_user    = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_X;
            side_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            k_reg       <= 2'd0;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                for (int i = 0; i < 4; i++) begin
                    avg_reg[s][i] <= '0;
                end
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        lines_reg <= job_data[8*C-1:0];
                        fb_reg    <= job_data[8*C+1:8*C];
                        ytop_reg  <= ytop_n;
                        side_reg  <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 4; i++) begin
                        l_reg[i] <= l_src[i];
                    end
                    dx_reg    <= dx_n;
                    dy_reg    <= dy_n;
                    phase_reg <= 1'b0;
                    if (dy_n == '0) begin
                        // flat line, averages stay as they are
                        if (!side_reg) begin
                            side_reg  <= 1'b1;
                            state_reg <= ST_LOAD;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        state_reg <= ST_CUT;
                    end
                end
                ST_CUT: begin
                    if (dx_reg == '0) begin
                        smp_reg[{phase_reg, 1'b0}] <= l_reg[0];
                        smp_reg[{phase_reg, 1'b1}] <= $signed({4'b0, yref});
                        if (!phase_reg) begin
                            phase_reg <= 1'b1;
                        end else begin
                            k_reg     <= 2'd0;
                            state_reg <= ST_FOLD;
                        end
                    end else begin
                        op_reg    <= OP_X;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_n;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_rsp.done) begin
                        unique case (op_reg)
                            OP_X: begin
                                smp_reg[{phase_reg, 1'b0}] <= cut_sat;
                                op_reg    <= OP_Y;
                                state_reg <= ST_MUL;
                            end
                            OP_Y: begin
                                smp_reg[{phase_reg, 1'b1}] <= cut_sat;
                                if (!phase_reg) begin
                                    phase_reg <= 1'b1;
                                    state_reg <= ST_CUT;
                                end else begin
                                    k_reg     <= 2'd0;
                                    state_reg <= ST_FOLD;
                                end
                            end
                            default: begin
                                avg_reg[side_reg][k_reg] <= div_rsp.quotient[15:0];
                                if (k_reg != 2'd3) begin
                                    k_reg     <= k_reg + 2'd1;
                                    state_reg <= ST_FOLD;
                                end else if (!side_reg) begin
                                    side_reg  <= 1'b1;
                                    state_reg <= ST_LOAD;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                        endcase
                    end
                end
                ST_FOLD: begin
                    if (avg_cur == '0) begin
                        avg_reg[side_reg][k_reg] <= smp_reg[k_reg];
                        if (k_reg != 2'd3) begin
                            k_reg <= k_reg + 2'd1;
                        end else if (!side_reg) begin
                            side_reg  <= 1'b1;
                            state_reg <= ST_LOAD;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        op_reg    <= OP_F;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int i = 0; i < 4; i++) begin
                            m_data_reg[16*i +: 16]     <= avg_reg[0][i];
                            m_data_reg[16*(4+i) +: 16] <= avg_reg[1][i];
                        end
                        m_user_reg  <= fb_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/lsst_checker.sv
// ----------------------------------------------------------------------------
// lsst_checker
// Port-level checks on the result channel of lane_segment_select_track
// ----------------------------------------------------------------------------
`default_nettype none

module lsst_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset drops the result request
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an offered result carries known data
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("result data unknown");

endmodule

bind lane_segment_select_track lsst_checker u_lsst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/lane_segment_select_track_tb.sv
// ----------------------------------------------------------------------------
// lane_segment_select_track_tb
// Drives segment requests and frame ends through the block, predicts the
// averaged lane lines of each frame and checks every result against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lane_segment_select_track_tb;

    typedef struct packed {
        logic [15:0] rby, rbx, rty, rtx, lby, lbx, lty, ltx;
        logic        rfb, lfb;
    } lane_result_t;

    typedef struct {
        logic        seg;
        logic [11:0] x1, y1, x2, y2;
        logic        last;
        logic        chk;
        lane_result_t res;
    } seg_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [11:0]  cfg_data;

    lane_segment_select_track uut (.*);

    // predictor state
    longint slope_thr, height, avg_len;
    longint lbest[4], rbest[4], lavg[4], ravg[4];
    longint llen, rlen;

    lane_result_t lane_q[$];
    seg_row_t     seg_rows[$];
    int           errors;
    int           mismatches;
    bit           quiet;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint tdiv(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    task automatic cut_line(input longint l[4], input longint yref,
                            output longint xo, output longint yo);
        longint dx, dy;
        dx = l[2] - l[0];
        dy = l[3] - l[1];
        if (dx == 0) begin
            xo = clip16(l[0]);
            yo = clip16(yref);
        end else begin
            xo = clip16(l[0] + tdiv((yref - l[1]) * dx, dy));
            yo = clip16(l[1] + tdiv((xo - l[0]) * dy, dx));
        end
    endtask

    function automatic longint fold_avg(longint a, longint s);
        longint n;
        n = (avg_len == 0) ? 1 : avg_len;
        if (a == 0) return s;
        return longint'(int'(tdiv(a * (n - 1) + s, n)));
    endfunction

    task automatic close_side(input longint best[4], input longint blen,
                              inout longint avg[4], output logic fb);
        longint l[4];
        longint yt, yb, tx, ty, bx, by;
        fb = (blen == 0);
        for (int i = 0; i < 4; i++) l[i] = fb ? avg[i] : best[i];
        if (l[3] - l[1] != 0) begin
            yb = height;
            yt = yb - yb / 3;
            cut_line(l, yt, tx, ty);
            cut_line(l, yb, bx, by);
            avg[0] = fold_avg(avg[0], tx);
            avg[1] = fold_avg(avg[1], ty);
            avg[2] = fold_avg(avg[2], bx);
            avg[3] = fold_avg(avg[3], by);
        end
    endtask

    task automatic predict_lanes(input seg_row_t r);
        longint dx, dy, len, c[4];
        int side;
        lane_result_t e;
        logic lf, rf;
        if (r.seg) begin
            c = '{longint'(r.x1), longint'(r.y1), longint'(r.x2), longint'(r.y2)};
            dx = c[2] - c[0];
            dy = c[3] - c[1];
            len = dx * dx + dy * dy;
            if (dx < 0) begin
                dx = -dx;
                dy = -dy;
            end
            side = 0;
            if (dx == 0) begin
                side = (dy < 0) ? 1 : (dy > 0) ? 2 : 0;
            end else if (dy * 256 < -slope_thr * dx) begin
                side = 1;
            end else if (dy * 256 > slope_thr * dx) begin
                side = 2;
            end
            if (side == 1 && len > llen) begin
                lbest = c;
                llen = len;
            end else if (side == 2 && len > rlen) begin
                rbest = c;
                rlen = len;
            end
        end
        if (r.last) begin
            close_side(lbest, llen, lavg, lf);
            close_side(rbest, rlen, ravg, rf);
            e.ltx = 16'(lavg[0]); e.lty = 16'(lavg[1]);
            e.lbx = 16'(lavg[2]); e.lby = 16'(lavg[3]);
            e.rtx = 16'(ravg[0]); e.rty = 16'(ravg[1]);
            e.rbx = 16'(ravg[2]); e.rby = 16'(ravg[3]);
            e.lfb = lf;
            e.rfb = rf;
            if (r.chk && e != r.res) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row mismatch: expected %h predicted %h", r.res, e);
            end
            lane_q.push_back(e);
            lbest = '{0, 0, 0, 0};
            rbest = '{0, 0, 0, 0};
            llen = 0;
            rlen = 0;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        unique case (idx)
            lsst_pkg::REG_SLOPE_LIMIT:    slope_thr = longint'(val[9:0]);
            lsst_pkg::REG_FRAME_HEIGHT:   height = longint'(val);
            lsst_pkg::REG_AVERAGE_LENGTH: avg_len = longint'(val[7:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_segment(input seg_row_t r);
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.seg;
        s_tlast  <= r.last;
        s_tdata  <= {r.y2, r.x2, r.y1, r.x1};
        predict_lanes(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (lane_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (400) @(posedge aclk);
    endtask

    function automatic seg_row_t rand_row(input int lastpct);
        seg_row_t r;
        int k;
        r.chk  = 1'b0;
        r.res  = '0;
        r.seg  = ($urandom_range(9) != 0);
        r.last = ($urandom_range(99) < lastpct);
        k = $urandom_range(9);
        r.x1 = 12'($urandom_range(4095));
        r.y1 = 12'($urandom_range(4095));
        if (k < 7) begin
            // plausible lane segment, small extent
            r.x2 = 12'(r.x1 + $urandom_range(0, 400) - 200);
            r.y2 = 12'(r.y1 + $urandom_range(0, 400) - 200);
        end else if (k == 7) begin
            r.x2 = r.x1;
            r.y2 = 12'($urandom_range(4095));
        end else begin
            r.x2 = 12'($urandom_range(4095));
            r.y2 = (k == 8) ? r.y1 : 12'($urandom_range(4095));
        end
        return r;
    endfunction

    // result checker and sink stalls
    always @(posedge aclk) begin
        lane_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[127:0], m_tuser[1], m_tuser[0]};
            if (lane_q.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = lane_q.pop_front();
                if (got != want) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    initial begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (quiet) begin
                m_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(4) == 0) begin
                hold = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        seg_row_t r;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lsst_pkg::REG_SLOPE_LIMIT;
        cfg_data = '0;
        aresetn = 1'b0;
        errors = 0;
        mismatches = 0;
        quiet = 1'b0;
        slope_thr = longint'(lsst_pkg::SLOPE_LIMIT_RESET);
        height = longint'(lsst_pkg::FRAME_HEIGHT_RESET);
        avg_len = longint'(lsst_pkg::AVERAGE_LENGTH_RESET);
        lbest = '{0, 0, 0, 0};
        rbest = '{0, 0, 0, 0};
        lavg = '{0, 0, 0, 0};
        ravg = '{0, 0, 0, 0};
        llen = 0;
        rlen = 0;

        // seg, x1, y1, x2, y2, last, checked, expected
        seg_rows.push_back('{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1,
                             lane_result_t'(2'b11)});
        seg_rows.push_back('{1'b1, 12'd5, 12'd5, 12'd5, 12'd5, 1'b1, 1'b1,
                             lane_result_t'(2'b11)});
        seg_rows.push_back('{1'b1, 12'd100, 12'd300, 12'd200, 12'd100, 1'b0, 0, '0});
        seg_rows.push_back('{1'b1, 12'd400, 12'd100, 12'd500, 12'd300, 1'b0, 0, '0});
        seg_rows.push_back('{1'b0, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0, 0, '0});
        seg_rows.push_back('{1'b1, 12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1, 0, '0});
        seg_rows.push_back('{1'b1, 12'd300, 12'd0, 12'd300, 12'd4095, 1'b0, 0, '0});
        seg_rows.push_back('{1'b1, 12'd700, 12'd4095, 12'd700, 12'd0, 1'b1, 0, '0});
        seg_rows.push_back('{1'b1, 12'd0, 12'd200, 12'd4095, 12'd200, 1'b1, 0, '0});
        seg_rows.push_back('{1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095, 1'b0, 0, '0});
        seg_rows.push_back('{1'b1, 12'd10, 12'd20, 12'd20, 12'd23, 1'b1, 0, '0});
        seg_rows.push_back('{1'b1, 12'd10, 12'd20, 12'd20, 12'd24, 1'b1, 0, '0});
        seg_rows.push_back('{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 0, '0});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (seg_rows[i]) send_segment(seg_rows[i]);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            unique case (ph)
                0: begin
                    write_reg(lsst_pkg::REG_SLOPE_LIMIT, 12'd0);
                    write_reg(lsst_pkg::REG_FRAME_HEIGHT, 12'd4095);
                    write_reg(lsst_pkg::REG_AVERAGE_LENGTH, 12'd1);
                end
                1: begin
                    write_reg(lsst_pkg::REG_SLOPE_LIMIT, 12'd1023);
                    write_reg(lsst_pkg::REG_FRAME_HEIGHT, 12'd1);
                    write_reg(lsst_pkg::REG_AVERAGE_LENGTH, 12'd255);
                end
                2: write_reg(lsst_pkg::REG_AVERAGE_LENGTH, 12'd0);
                default: begin
                    write_reg(lsst_pkg::REG_SLOPE_LIMIT, 12'($urandom_range(1023)));
                    write_reg(lsst_pkg::REG_FRAME_HEIGHT, 12'($urandom_range(1, 4095)));
                    write_reg(lsst_pkg::REG_AVERAGE_LENGTH, 12'($urandom_range(1, 255)));
                end
            endcase
            quiet = (ph == 5);
            for (int n = 0; n < 115; n++) send_segment(rand_row(20));
            r = rand_row(0);
            r.last = 1'b1;
            send_segment(r);
            drain_results();
        end

        if (errors == 0 && lane_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lsst_pkg.sv
hdl/lsst_fifo.sv
hdl/lsst_front.sv
hdl/lsst_div.sv
hdl/lsst_back.sv
hdl/lane_segment_select_track.sv
hdl/lsst_checker.sv
tb/lane_segment_select_track_tb.sv
